/* rtl/core/gsdn_pkg.sv */
// Shared constants and types for the gamepad stick dead-zone normalizer.
`default_nettype none
package gsdn_pkg;

  // Magnitude carries this many fraction bits after the square root.
  localparam int unsigned MAG_FRAC   = 8;
  // Root width: floor(sqrt(2^31 * 2^16)) fits in 24 bits.
  localparam int unsigned SQRT_W     = 24;
  // Register stages ahead of the square root: squares, then their sum.
  localparam int unsigned PRE_STAGES = 2;
  // Dividend width of a direction component: |c| * 2^(15+MAG_FRAC) plus half the root.
  localparam int unsigned DIR_N_W    = 16 + 15 + MAG_FRAC;

  localparam logic [7:0] TRIG_FULL = 8'd255;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_THR   = 2'd2;

  // What one stick lane hands to the output stage.
  typedef struct packed {
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] level;
  } stick_res_t;

endpackage
`default_nettype wire

/* rtl/core/gsdn_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
`default_nettype none
module gsdn_div #(
  parameter int unsigned N_W   = 39,
  parameter int unsigned D_W   = 24,
  parameter int unsigned Q_W   = 17,
  parameter int unsigned TAG_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [N_W-1:0]   dividend_i,
  input  wire logic [D_W-1:0]   divisor_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  valid_o,
  output logic [Q_W-1:0]        quot_o,
  output logic [TAG_W-1:0]      tag_o
);
  localparam int unsigned R_W = D_W + Q_W;

  logic [R_W-1:0]   rem_q [Q_W];
  logic [D_W-1:0]   den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [TAG_W-1:0] tag_q [Q_W];
  logic [Q_W-1:0]   vld_q;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [R_W-1:0]   rem_in;
    logic [R_W-1:0]   sub;
    logic [D_W-1:0]   den_in;
    logic [Q_W-1:0]   quo_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = R_W'(dividend_i);
      assign den_in = divisor_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign tag_in = tag_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    // Trial subtract of the divisor at this bit's weight.
    assign sub = R_W'(den_in) << (Q_W - 1 - k);
    assign ge  = (rem_in >= sub);

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? (rem_in - sub) : rem_in;
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[Q_W-2:0], ge};
      tag_q[k] <= tag_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quot_o  = quo_q[Q_W-1];
  assign tag_o   = tag_q[Q_W-1];
endmodule
`default_nettype wire

/* rtl/core/gsdn_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with a side tag.
`default_nettype none
module gsdn_sqrt #(
  parameter int unsigned RT_W  = 24,
  parameter int unsigned TAG_W = 34
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [2*RT_W-1:0] rad_i,
  input  wire logic [TAG_W-1:0]  tag_i,
  output logic                   valid_o,
  output logic [RT_W-1:0]        root_o,
  output logic [TAG_W-1:0]       tag_o
);
  localparam int unsigned V_W = 2 * RT_W;
  localparam int unsigned M_W = RT_W + 2;

  logic [M_W-1:0]   rem_q  [RT_W];
  logic [RT_W-1:0]  root_q [RT_W];
  logic [V_W-1:0]   rad_q  [RT_W];
  logic [TAG_W-1:0] tag_q  [RT_W];
  logic [RT_W-1:0]  vld_q;

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    localparam int unsigned I = RT_W - 1 - k;
    logic [M_W-1:0]   rem_in;
    logic [RT_W-1:0]  root_in;
    logic [V_W-1:0]   rad_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic [M_W-1:0]   rem_sh;
    logic [M_W-1:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign tag_in  = tag_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign tag_in  = tag_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_in[M_W-3:0], rad_in[2*I+1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[k] <= {root_in[RT_W-2:0], ge};
      rad_q[k]  <= rad_in;
      tag_q[k]  <= tag_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[RT_W-1];
  assign root_o  = root_q[RT_W-1];
  assign tag_o   = tag_q[RT_W-1];
endmodule
`default_nettype wire

/* rtl/core/gsdn_stick.sv */
// One stick lane: magnitude, dead-zone and clip tests, direction and level.
`default_nettype none
module gsdn_stick #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DIV_QW    = 17
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [15:0] y_i,
  input  wire logic [15:0]        dead_zone_i,
  input  wire logic [15:0]        max_radius_i,
  input  wire logic [31:0]        dz_sq_i,
  input  wire logic [31:0]        mx_sq_i,
  output logic                    valid_o,
  output gsdn_pkg::stick_res_t    res_o
);
  import gsdn_pkg::*;

  localparam int unsigned TAG_W = 2 + 32;
  localparam int unsigned LVL_N_W = SQRT_W + FRAC_BITS;

  logic signed [31:0] xx_s, yy_s;
  logic [31:0]        xx_q, yy_q, s_q;
  logic [15:0]        x1_q, y1_q, x2_q, y2_q;
  logic               v1_q, v2_q;

  logic               dz_flag, clip_flag;
  logic [TAG_W-1:0]   sq_tag;
  logic               sq_valid;
  logic [SQRT_W-1:0]  mag;
  logic [TAG_W-1:0]   mag_tag;
  logic [15:0]        mx_u, my_u, ax, ay;

  logic [DIR_N_W-1:0] nx, ny;
  logic [SQRT_W-1:0]  lvl_num, lvl_den;
  logic [15:0]        span;

  logic               vx, vy, vl;
  logic [DIV_QW-1:0]  qx, qy, ql;
  logic               sx, sy;
  logic [1:0]         fl;
  logic [DIV_QW+15:0] lvl_wide;

  assign xx_s = 32'(x_i) * 32'(x_i);
  assign yy_s = 32'(y_i) * 32'(y_i);

  always_ff @(posedge clk_i) begin
    xx_q <= $unsigned(xx_s);
    yy_q <= $unsigned(yy_s);
    x1_q <= x_i;
    y1_q <= y_i;
    s_q  <= xx_q + yy_q;
    x2_q <= x1_q;
    y2_q <= y1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign dz_flag   = (s_q <= dz_sq_i);
  assign clip_flag = (s_q >= mx_sq_i);
  assign sq_tag    = {dz_flag, clip_flag, x2_q, y2_q};

  gsdn_sqrt #(
    .RT_W  (SQRT_W),
    .TAG_W (TAG_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .rad_i   ({s_q, {(2*MAG_FRAC){1'b0}}}),
    .tag_i   (sq_tag),
    .valid_o (sq_valid),
    .root_o  (mag),
    .tag_o   (mag_tag)
  );

  assign mx_u = mag_tag[31:16];
  assign my_u = mag_tag[15:0];
  assign ax   = mx_u[15] ? (~mx_u + 16'd1) : mx_u;
  assign ay   = my_u[15] ? (~my_u + 16'd1) : my_u;

  // Round half up: add half the magnitude before dividing.
  assign nx = {ax, {(15+MAG_FRAC){1'b0}}} + DIR_N_W'(mag >> 1);
  assign ny = {ay, {(15+MAG_FRAC){1'b0}}} + DIR_N_W'(mag >> 1);

  assign span    = max_radius_i - dead_zone_i;
  assign lvl_num = mag - {dead_zone_i, {MAG_FRAC{1'b0}}};
  assign lvl_den = {span, {MAG_FRAC{1'b0}}};

  gsdn_div #(
    .N_W (DIR_N_W), .D_W (SQRT_W), .Q_W (DIV_QW), .TAG_W (1)
  ) u_div_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sq_valid),
    .dividend_i (nx), .divisor_i (mag), .tag_i (mx_u[15]),
    .valid_o (vx), .quot_o (qx), .tag_o (sx)
  );

  gsdn_div #(
    .N_W (DIR_N_W), .D_W (SQRT_W), .Q_W (DIV_QW), .TAG_W (1)
  ) u_div_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sq_valid),
    .dividend_i (ny), .divisor_i (mag), .tag_i (my_u[15]),
    .valid_o (vy), .quot_o (qy), .tag_o (sy)
  );

  gsdn_div #(
    .N_W (LVL_N_W), .D_W (SQRT_W), .Q_W (DIV_QW), .TAG_W (2)
  ) u_div_lvl (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sq_valid),
    .dividend_i ({lvl_num, {FRAC_BITS{1'b0}}}), .divisor_i (lvl_den),
    .tag_i (mag_tag[33:32]),
    .valid_o (vl), .quot_o (ql), .tag_o (fl)
  );

  // Align the level quotient to 16 fraction bits.
  assign lvl_wide = {ql, 16'd0} >> FRAC_BITS;

  function automatic logic [15:0] dir_sat(input logic neg, input logic [DIV_QW-1:0] q);
    logic [15:0] qc;
    qc = 16'h0000;
    if (neg) begin
      qc = (q > DIV_QW'(32768)) ? 16'h8000 : q[15:0];
      return ~qc + 16'd1;
    end
    return (q > DIV_QW'(32767)) ? 16'h7fff : q[15:0];
  endfunction

  assign valid_o = vx & vy & vl;

  always_comb begin
    if (fl[1]) begin
      res_o = '0;
    end else begin
      res_o.dir_x = dir_sat(sx, qx);
      res_o.dir_y = dir_sat(sy, qy);
      res_o.level = fl[0] ? 16'hffff : lvl_wide[15:0];
    end
  end
endmodule
`default_nettype wire

/* rtl/core/gsdn_trig.sv */
// Trigger lane: hold the reading level with the sticks, then rescale past the threshold.
`default_nettype none
module gsdn_trig #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DIV_QW    = 17,
  parameter int unsigned DELAY     = 26
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [7:0]  trig_i,
  input  wire logic [7:0]  thr_i,
  output logic             valid_o,
  output logic [15:0]      level_o
);
  import gsdn_pkg::*;

  logic [7:0]         t_q [DELAY];
  logic [DELAY-1:0]   v_q;
  logic [7:0]         td;
  logic               gt, gt_o;
  logic [DIV_QW-1:0]  q;
  logic [DIV_QW+15:0] wide;

  always_ff @(posedge clk_i) begin
    t_q[0] <= trig_i;
    for (int k = 1; k < DELAY; k++) begin
      t_q[k] <= t_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[DELAY-2:0], valid_i};
    end
  end

  assign td = t_q[DELAY-1];
  assign gt = (td > thr_i);

  gsdn_div #(
    .N_W (8 + FRAC_BITS), .D_W (8), .Q_W (DIV_QW), .TAG_W (1)
  ) u_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (v_q[DELAY-1]),
    .dividend_i ({td - thr_i, {FRAC_BITS{1'b0}}}), .divisor_i (TRIG_FULL - thr_i),
    .tag_i (gt),
    .valid_o (valid_o), .quot_o (q), .tag_o (gt_o)
  );

  // Align to 16 fraction bits and saturate full scale.
  assign wide = {q, 16'd0} >> FRAC_BITS;

  always_comb begin
    if (!gt_o) begin
      level_o = 16'd0;
    end else if (|wide[DIV_QW+15:16]) begin
      level_o = 16'hffff;
    end else begin
      level_o = wide[15:0];
    end
  end
endmodule
`default_nettype wire

/* rtl/core/gamepad_stick_deadzone_normalizer_top.sv */
// Top level of the gamepad stick dead-zone normalizer.
// Throughput: one report per cycle; busy_o never rises, every stage is a fixed pipeline.
// The 24-stage square root and the bit-per-stage dividers set the latency.
// Results show on valid_o for one cycle; the receiver cannot stall.
// Reset clears the configuration to its defaults and empties the pipeline valids.
`default_nettype none
module gamepad_stick_deadzone_normalizer_top #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // report request
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic signed [15:0]             left_x_i,
  input  wire logic signed [15:0]             left_y_i,
  input  wire logic signed [15:0]             right_x_i,
  input  wire logic signed [15:0]             right_y_i,
  input  wire logic [7:0]                     trigger_raw_i,
  // result
  output logic                                valid_o,
  output logic signed [15:0]                  left_dir_x_o,
  output logic signed [15:0]                  left_dir_y_o,
  output logic [15:0]                         left_level_o,
  output logic signed [15:0]                  right_dir_x_o,
  output logic signed [15:0]                  right_dir_y_o,
  output logic [15:0]                         right_level_o,
  output logic [15:0]                         trigger_level_o,
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [gsdn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i
);
  import gsdn_pkg::*;

  // Quotient width covers full scale (2^FRACTION_BITS) and a Q1.15 direction.
  localparam int unsigned DIV_QW = (FRACTION_BITS + 1 > 16) ? FRACTION_BITS + 1 : 16;

  logic [15:0] dead_zone_q, max_radius_q;
  logic [7:0]  trig_thr_q;
  logic [31:0] dz_sq_q, mx_sq_q;
  logic        accept;

  logic        l_valid, r_valid, t_valid;
  stick_res_t  l_res, r_res;
  logic [15:0] t_level;

  logic        valid_q;
  stick_res_t  l_res_q, r_res_q;
  logic [15:0] t_level_q;

  // Always ready: the pipeline takes a request every cycle.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  // Configuration registers; unknown indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q  <= 16'd7849;
      max_radius_q <= 16'd32767;
      trig_thr_q   <= 8'd30;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEAD_ZONE:  dead_zone_q  <= cfg_data_i;
        CFG_MAX_RADIUS: max_radius_q <= cfg_data_i;
        CFG_TRIG_THR:   trig_thr_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Hold the squared radii for the dead-zone and clip compares.
  always_ff @(posedge clk_i) begin
    dz_sq_q <= 32'(dead_zone_q) * 32'(dead_zone_q);
    mx_sq_q <= 32'(max_radius_q) * 32'(max_radius_q);
  end

  gsdn_stick #(
    .FRAC_BITS (FRACTION_BITS),
    .DIV_QW    (DIV_QW)
  ) u_left (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .x_i          (left_x_i),
    .y_i          (left_y_i),
    .dead_zone_i  (dead_zone_q),
    .max_radius_i (max_radius_q),
    .dz_sq_i      (dz_sq_q),
    .mx_sq_i      (mx_sq_q),
    .valid_o      (l_valid),
    .res_o        (l_res)
  );

  gsdn_stick #(
    .FRAC_BITS (FRACTION_BITS),
    .DIV_QW    (DIV_QW)
  ) u_right (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .x_i          (right_x_i),
    .y_i          (right_y_i),
    .dead_zone_i  (dead_zone_q),
    .max_radius_i (max_radius_q),
    .dz_sq_i      (dz_sq_q),
    .mx_sq_i      (mx_sq_q),
    .valid_o      (r_valid),
    .res_o        (r_res)
  );

  // Trigger waits out the squares and the root so all lanes line up.
  gsdn_trig #(
    .FRAC_BITS (FRACTION_BITS),
    .DIV_QW    (DIV_QW),
    .DELAY     (PRE_STAGES + SQRT_W)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .trig_i  (trigger_raw_i),
    .thr_i   (trig_thr_q),
    .valid_o (t_valid),
    .level_o (t_level)
  );

  // Merge the lanes into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= l_valid & r_valid & t_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    l_res_q   <= l_res;
    r_res_q   <= r_res;
    t_level_q <= t_level;
  end

  assign valid_o         = valid_q;
  assign left_dir_x_o    = l_res_q.dir_x;
  assign left_dir_y_o    = l_res_q.dir_y;
  assign left_level_o    = l_res_q.level;
  assign right_dir_x_o   = r_res_q.dir_x;
  assign right_dir_y_o   = r_res_q.dir_y;
  assign right_level_o   = r_res_q.level;
  assign trigger_level_o = t_level_q;
endmodule
`default_nettype wire
